>>> rtl/cre_pkg.sv
// Package for the character range expander: command type, queue sizing,
// character classes and constants. Depends on nothing; used by every rtl file.
package cre_pkg;

	localparam logic [7:0]  HYPHEN        = 8'h2D;
	localparam logic [11:0] MAX_LEN_RESET = 12'd1000;

	// Depth of the command queue between front and back
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	typedef enum logic [1:0] {
		CC_NONE,
		CC_DIGIT,
		CC_UPPER,
		CC_LOWER
	} char_class_t;

	// One command: a run of consecutive bytes, then up to two flushed bytes,
	// cut to emit_cnt results in all
	typedef struct packed {
		logic [7:0] base;
		logic [4:0] run_len;
		logic [7:0] flush0;
		logic [7:0] flush1;
		logic [4:0] emit_cnt;
		logic       ovf;
		logic       line_end;
	} cmd_t;

	function automatic char_class_t char_class(input logic [7:0] ch);
		char_class_t k;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			k = CC_DIGIT;
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			k = CC_UPPER;
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			k = CC_LOWER;
		end else begin
			k = CC_NONE;
		end
		return k;
	endfunction

	function automatic logic range_ok(input logic [7:0] lo, input logic [7:0] hi);
		char_class_t kl;
		kl = char_class(lo);
		return (kl != CC_NONE) && (kl == char_class(hi)) && (hi > lo);
	endfunction

endpackage

>>> rtl/cre_front.sv
// Front part: accepts characters, keeps the two-byte window and line count,
// and turns characters into result commands. Depends on cre_pkg.
module cre_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	output logic              full,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [11:0]       cfg_max_len,
	input  logic              q_full,
	output logic              cmd_push,
	output cre_pkg::cmd_t     cmd
);

	logic [11:0] max_len_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic [1:0]  count_q;
	logic [11:0] written_q;
	logic        dropping_q;

	logic        accept;
	logic [7:0]  base;
	logic [4:0]  run_len;
	logic [7:0]  nfirst;
	logic [7:0]  nsecond;
	logic [1:0]  ncount;
	logic [4:0]  nflush;
	logic [4:0]  total;
	logic [12:0] limit;
	logic        ovf;
	logic [4:0]  emit_cnt;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;

	// Classify the window against the new character
	always_comb begin
		base    = first_q;
		run_len = 5'd0;
		nfirst  = first_q;
		nsecond = second_q;
		ncount  = count_q;
		if (count_q >= 2'd2) begin
			if (second_q == cre_pkg::HYPHEN && cre_pkg::range_ok(first_q, in_char)) begin
				run_len = 5'(in_char - first_q);
				nfirst  = in_char;
				ncount  = 2'd1;
			end else begin
				run_len = 5'd1;
				nfirst  = second_q;
				nsecond = in_char;
				ncount  = 2'd2;
			end
		end else if (count_q == 2'd1) begin
			nsecond = in_char;
			ncount  = 2'd2;
		end else begin
			nfirst = in_char;
			ncount = 2'd1;
		end
		nflush = in_last ? {3'd0, ncount} : 5'd0;
		total  = run_len + nflush;
		// Results left before the count reaches max_len
		if (written_q >= max_len_q) begin
			limit = 13'd1;
		end else begin
			limit = {1'b0, max_len_q} - {1'b0, written_q};
		end
		ovf      = (total != 5'd0) && ({8'd0, total} >= limit);
		emit_cnt = ovf ? limit[4:0] : total;
	end

	// Build the command
	always_comb begin
		cmd.base     = base;
		cmd.run_len  = run_len;
		cmd.flush0   = nfirst;
		cmd.flush1   = nsecond;
		cmd.emit_cnt = emit_cnt;
		cmd.ovf      = ovf;
		cmd.line_end = ovf || in_last;
		cmd_push     = accept && !dropping_q && (total != 5'd0);
	end

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= cre_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_max_len;
		end
	end

	// Advance the window and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 8'd0;
			second_q   <= 8'd0;
			count_q    <= 2'd0;
			written_q  <= 12'd0;
			dropping_q <= 1'b0;
		end else if (accept) begin
			if (dropping_q) begin
				if (in_last) begin
					dropping_q <= 1'b0;
				end
			end else if (ovf || in_last) begin
				first_q    <= 8'd0;
				second_q   <= 8'd0;
				count_q    <= 2'd0;
				written_q  <= 12'd0;
				dropping_q <= ovf && !in_last;
			end else begin
				first_q   <= nfirst;
				second_q  <= nsecond;
				count_q   <= ncount;
				written_q <= written_q + {7'd0, total};
			end
		end
	end

endmodule

>>> rtl/cre_cmd_fifo.sv
// Short command queue between the front and back parts.
// Depends on cre_pkg for the command type and depth.
module cre_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cre_pkg::cmd_t wr_data,
	output logic          q_full,
	input  logic          rd_en,
	output logic          q_empty,
	output cre_pkg::cmd_t rd_data
);

	cre_pkg::cmd_t                   mem_q [cre_pkg::CMD_DEPTH];
	logic [cre_pkg::CMD_PTR_W-1:0]   wr_ptr_q;
	logic [cre_pkg::CMD_PTR_W-1:0]   rd_ptr_q;
	logic [cre_pkg::CMD_CNT_W-1:0]   cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign q_full  = (cnt_q == cre_pkg::CMD_CNT_W'(cre_pkg::CMD_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == cre_pkg::CMD_PTR_W'(cre_pkg::CMD_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == cre_pkg::CMD_PTR_W'(cre_pkg::CMD_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/cre_back.sv
// Back part: plays out one command as a sequence of result beats.
// Depends on cre_pkg for the command type.
module cre_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  cre_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_char,
	output logic          run_end,
	output logic          line_end,
	output logic          overflow
);

	cre_pkg::cmd_t cmd_q;
	logic          active_q;
	logic [4:0]    idx_q;
	logic          final_beat;
	logic          taken;

	assign empty      = !active_q;
	assign taken      = active_q && pop;
	assign final_beat = (idx_q == cmd_q.emit_cnt - 5'd1);
	assign q_pop      = !q_empty && (!active_q || (taken && final_beat));

	// Select the byte of the current beat
	always_comb begin
		if (idx_q < cmd_q.run_len) begin
			out_char = cmd_q.base + {3'd0, idx_q};
		end else if (idx_q == cmd_q.run_len) begin
			out_char = cmd_q.flush0;
		end else begin
			out_char = cmd_q.flush1;
		end
		run_end  = final_beat;
		line_end = final_beat && cmd_q.line_end;
		overflow = final_beat && cmd_q.ovf;
	end

	// Hold the command being played out
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
	end

	// Advance the beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= 5'd0;
		end else if (q_pop) begin
			active_q <= 1'b1;
			idx_q    <= 5'd0;
		end else if (taken) begin
			if (final_beat) begin
				active_q <= 1'b0;
				idx_q    <= 5'd0;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

endmodule

>>> rtl/character_range_expander.sv
// Top level of the character range expander: front, command queue, back.
// Depends on cre_pkg, cre_front, cre_cmd_fifo and cre_back.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  input    | push / full      | in_char[7:0], in_last
//  result   | pop / empty      | out_char[7:0], run_end, line_end, overflow
//  config   | cfg_valid/ready  | cfg_max_len[11:0]
//
// A character is taken whenever the two-entry command queue has room; the
// back part plays out each command beat by beat as pop takes them, so a long
// range holds the back part while the front keeps taking input until the
// queue fills. Reset clears window, count and queue at once and loads
// max_len with 1000; config is always ready.
module character_range_expander (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_char,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_char,
	output logic        run_end,
	output logic        line_end,
	output logic        overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_max_len
);

	cre_pkg::cmd_t wr_cmd;
	cre_pkg::cmd_t rd_cmd;
	logic          cmd_push;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;

	cre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_char     (in_char),
		.in_last     (in_last),
		.full        (full),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_max_len (cfg_max_len),
		.q_full      (q_full),
		.cmd_push    (cmd_push),
		.cmd         (wr_cmd)
	);

	cre_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (wr_cmd),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_data (rd_cmd)
	);

	cre_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (rd_cmd),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_char (out_char),
		.run_end  (run_end),
		.line_end (line_end),
		.overflow (overflow)
	);

endmodule

>>> dv/tb_character_range_expander.sv
// Testbench for character_range_expander: directed and random lines, with a
// scoreboard that predicts every expanded beat. Depends on cre_pkg and the RTL.
`timescale 1ns / 100ps

module tb_character_range_expander;

	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PRESSURE_HOLD = 300;

	typedef struct {
		logic [7:0] out_char;
		logic       run_end;
		logic       line_end;
		logic       overflow;
	} expansion_beat_t;

	// Line state and the beats still owed by the block
	class expansion_scoreboard;
		logic [11:0]     max_len;
		logic [7:0]      win_first;
		logic [7:0]      win_second;
		logic [1:0]      win_count;
		logic [11:0]     out_count;
		bit              dropping;
		expansion_beat_t pending[$];
		int              errors;

		function new();
			max_len = cre_pkg::MAX_LEN_RESET;
			errors  = 0;
			clear_line();
		endfunction

		function void clear_line();
			win_first  = 8'h00;
			win_second = 8'h00;
			win_count  = 2'd0;
			out_count  = 12'd0;
			dropping   = 1'b0;
		endfunction

		function cre_pkg::char_class_t classify(input logic [7:0] ch);
			if (ch >= "0" && ch <= "9") begin
				return cre_pkg::CC_DIGIT;
			end
			if (ch >= "A" && ch <= "Z") begin
				return cre_pkg::CC_UPPER;
			end
			if (ch >= "a" && ch <= "z") begin
				return cre_pkg::CC_LOWER;
			end
			return cre_pkg::CC_NONE;
		endfunction

		// Queue one beat; true once the line count reaches max_len
		function bit emit(input logic [7:0] ch);
			expansion_beat_t b;
			b.out_char = ch;
			b.run_end  = 1'b0;
			b.line_end = 1'b0;
			b.overflow = 1'b0;
			pending.push_back(b);
			out_count = out_count + 12'd1;
			return out_count >= max_len;
		endfunction

		function void note_input(input logic [7:0] c, input logic last);
			int                   first_idx;
			int                   code;
			bit                   ovf;
			cre_pkg::char_class_t k;
			first_idx = pending.size();
			ovf       = 1'b0;
			// Swallow the rest of an abandoned line
			if (dropping) begin
				if (last) begin
					clear_line();
				end
				return;
			end
			if (win_count == 2'd2) begin
				k = classify(win_first);
				if (win_second == cre_pkg::HYPHEN && k != cre_pkg::CC_NONE
						&& k == classify(c) && c > win_first) begin
					// Expand the range up to c-1 and keep c as the next start
					for (code = win_first; code < c && !ovf; code++) begin
						ovf = emit(8'(code));
					end
					win_first = c;
					win_count = 2'd1;
				end else begin
					ovf        = emit(win_first);
					win_first  = win_second;
					win_second = c;
				end
			end else if (win_count == 2'd1) begin
				win_second = c;
				win_count  = 2'd2;
			end else begin
				win_first = c;
				win_count = 2'd1;
			end
			// Flush the window at the end of the line
			if (!ovf && last) begin
				ovf = emit(win_first);
				if (!ovf && win_count == 2'd2) begin
					ovf = emit(win_second);
				end
			end
			if (pending.size() > first_idx) begin
				pending[pending.size() - 1].run_end = 1'b1;
			end
			if (ovf) begin
				pending[pending.size() - 1].line_end = 1'b1;
				pending[pending.size() - 1].overflow = 1'b1;
				clear_line();
				dropping = !last;
			end else if (last) begin
				pending[pending.size() - 1].line_end = 1'b1;
				clear_line();
			end
		endfunction

		function void check_result(input logic [7:0] ch, input logic re,
				input logic le, input logic ov);
			expansion_beat_t b;
			if (pending.size() == 0) begin
				$error("unexpected beat: out_char=%h run_end=%b line_end=%b overflow=%b",
					ch, re, le, ov);
				errors++;
				return;
			end
			b = pending.pop_front();
			if (ch !== b.out_char) begin
				$error("out_char: expected %h, actual %h", b.out_char, ch);
				errors++;
			end
			if (re !== b.run_end) begin
				$error("run_end: expected %b, actual %b", b.run_end, re);
				errors++;
			end
			if (le !== b.line_end) begin
				$error("line_end: expected %b, actual %b", b.line_end, le);
				errors++;
			end
			if (ov !== b.overflow) begin
				$error("overflow: expected %b, actual %b", b.overflow, ov);
				errors++;
			end
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic        full;
	logic [7:0]  in_char     = 8'h00;
	logic        in_last     = 1'b0;
	logic        empty;
	logic        pop         = 1'b0;
	logic [7:0]  out_char;
	logic        run_end;
	logic        line_end;
	logic        overflow;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_max_len = 12'd0;

	expansion_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pop_hold      = 0;
	int stall_cycles  = 0;
	int items_sent    = 0;

	character_range_expander u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_char     (in_char),
		.in_last     (in_last),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.run_end     (run_end),
		.line_end    (line_end),
		.overflow    (overflow),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_max_len (cfg_max_len)
	);

	always #4 clk = ~clk;

	// Take result beats, with random stalls and the occasional long hold-off
	always begin
		@(posedge clk);
		if (arst_n && pop && !empty) begin
			sb.check_result(out_char, run_end, line_end, overflow);
		end
		@(negedge clk);
		if (pop_hold > 0) begin
			pop_hold = pop_hold - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Abort when no beat of any kind moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] ch, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		in_char <= ch;
		in_last <= last;
		forever begin
			@(posedge clk);
			if (!full) begin
				break;
			end
		end
		sb.note_input(ch, last);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], i == s.len() - 1);
		end
	endtask

	// Drop push, then wait for every owed beat and let the pipeline settle
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [11:0] value);
		@(negedge clk);
		cfg_valid   <= 1'b1;
		cfg_max_len <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready) begin
				break;
			end
		end
		sb.max_len = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] class_base(input cre_pkg::char_class_t k);
		case (k)
			cre_pkg::CC_DIGIT: return "0";
			cre_pkg::CC_UPPER: return "A";
			default:           return "a";
		endcase
	endfunction

	function automatic int class_span(input cre_pkg::char_class_t k);
		return (k == cre_pkg::CC_DIGIT) ? 10 : 26;
	endfunction

	// One line of tokens: mostly proper ranges, some hyphens, broken ranges and noise
	task automatic send_random_line();
		logic [7:0]           line[$];
		int                   tokens;
		int                   pick;
		int                   top;
		cre_pkg::char_class_t k;
		logic [7:0]           lo;
		logic [7:0]           hi;
		tokens = $urandom_range(1, 4);
		repeat (tokens) begin
			pick = $urandom_range(99);
			k    = cre_pkg::char_class_t'($urandom_range(1, 3));
			top  = class_base(k) + class_span(k) - 1;
			if (pick < 50) begin
				lo = 8'(class_base(k) + $urandom_range(class_span(k) - 2));
				hi = 8'(lo + $urandom_range(1, top - lo));
				line.push_back(lo);
				line.push_back(cre_pkg::HYPHEN);
				line.push_back(hi);
				if (hi < top && $urandom_range(99) < 35) begin
					line.push_back(cre_pkg::HYPHEN);
					line.push_back(8'(hi + $urandom_range(1, top - hi)));
				end
			end else if (pick < 62) begin
				line.push_back(cre_pkg::HYPHEN);
			end else if (pick < 72) begin
				line.push_back(8'(class_base(k) + $urandom_range(class_span(k) - 1)));
				line.push_back(cre_pkg::HYPHEN);
				k = cre_pkg::char_class_t'($urandom_range(0, 3));
				line.push_back((k == cre_pkg::CC_NONE) ? 8'($urandom_range(255))
					: 8'(class_base(k) + $urandom_range(class_span(k) - 1)));
			end else if (pick < 85) begin
				line.push_back(8'(class_base(k) + $urandom_range(class_span(k) - 1)));
			end else begin
				line.push_back(8'($urandom_range(255)));
			end
		end
		foreach (line[i]) begin
			send_item(line[i], i == line.size() - 1);
		end
	endtask

	task automatic run_phase(input int s_idle, input int r_idle,
			input logic [11:0] limit, input int count, input int hold);
		int target;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		write_max_len(limit);
		pop_hold = hold;
		target   = items_sent + count;
		while (items_sent < target) begin
			send_random_line();
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed lines at the reset length limit
		send_idle_pct = 26;
		recv_idle_pct = 69;
		send_text("-a-c-e-");
		send_text("A-Z");
		send_text("9-0-A");
		send_item(8'h80, 1'b0);
		send_item(cre_pkg::HYPHEN, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);
		drain();

		// Overflow inside a range with the tail dropped, then on the last character
		write_max_len(12'd4);
		send_text("a-z12");
		send_text("wxyz");
		drain();

		run_phase(26, 69, 12'd4095, 24, 0);
		run_phase(69, 26, 12'($urandom_range(3, 30)), 24, 0);
		run_phase(0, 0, 12'd1, 8, 0);
		run_phase(0, 0, 12'($urandom_range(8, 60)), 24, PRESSURE_HOLD);

		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> character_range_expander.f
rtl/cre_pkg.sv
rtl/cre_front.sv
rtl/cre_cmd_fifo.sv
rtl/cre_back.sv
rtl/character_range_expander.sv
dv/tb_character_range_expander.sv
